/* rtl/assert_macros.svh */
// Assertion macros used by the CSV field parser top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* rtl/csvp_pkg.sv */
// Types and constants shared by the CSV field parser modules.
`timescale 1ns / 1ps

package csvp_pkg;

    localparam logic [7:0] CH_CR        = 8'd13;
    localparam logic [7:0] CH_LF        = 8'd10;
    localparam logic [7:0] CH_NUL       = 8'd0;
    localparam logic [7:0] DELIM_RESET  = 8'd44;
    localparam logic [7:0] QUOTE_RESET  = 8'd34;
    localparam logic [31:0] LINE_RESET  = 32'd1;

    localparam logic [1:0] REG_DELIMITER = 2'd0;
    localparam logic [1:0] REG_QUOTE     = 2'd1;
    localparam logic [1:0] REG_LENIENT   = 2'd2;

    typedef enum logic [1:0] {
        MODE_READ  = 2'd0,
        MODE_QUOTE = 2'd1,
        MODE_SKIP  = 2'd2,
        MODE_DONE  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ERR_NONE           = 2'd0,
        ERR_UNESCAPED      = 2'd1,
        ERR_QUOTE_IN_PLAIN = 2'd2,
        ERR_UNTERMINATED   = 2'd3
    } err_t;

    typedef struct packed {
        logic [7:0] delimiter;
        logic [7:0] quote_char;
        logic       lenient;
    } cfg_t;

    typedef struct packed {
        mode_t       mode;
        logic        in_quotes;
        logic        field_nonempty;
        err_t        err;
        logic [31:0] line;
        logic [31:0] col;
    } state_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       at_end;
    } item_t;

    typedef struct packed {
        logic [1:0] count;
        logic [7:0] first;
        logic [7:0] second;
        logic       fend;
        logic       rend;
        logic       done;
    } res_t;

    typedef struct packed {
        res_t        res;
        err_t        err;
        logic [31:0] line;
        logic [31:0] col;
    } result_t;

endpackage

/* rtl/csvp_in_stage.sv */
// Input register stage of the CSV field parser.
`timescale 1ns / 1ps

module csvp_in_stage
    import csvp_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  advance,
    input  logic  in_valid,
    input  item_t in_item,
    output logic  item_valid,
    output item_t item
);

    logic  valid_reg;
    item_t item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

/* rtl/csvp_step.sv */
// Per-byte parse step: next parser state and result for one item.
`timescale 1ns / 1ps

module csvp_step
    import csvp_pkg::*;
(
    input  cfg_t    cfg,
    input  state_t  st,
    input  item_t   item,
    output state_t  st_next,
    output result_t result
);

    typedef struct packed {
        state_t st;
        res_t   res;
    } ctx_t;

    function automatic ctx_t push_byte(ctx_t x, logic [7:0] b);
        ctx_t y;
        y = x;
        if (y.res.count == 2'd0)
        begin
            y.res.first = b;
        end
        else
        begin
            y.res.second = b;
        end
        y.res.count = y.res.count + 2'd1;
        y.st.field_nonempty = 1'b1;
        return y;
    endfunction

    function automatic ctx_t close_field(ctx_t x, logic row);
        ctx_t y;
        y = x;
        y.res.fend = 1'b1;
        y.st.in_quotes = 1'b0;
        y.st.field_nonempty = 1'b0;
        if (row)
        begin
            y.res.rend = 1'b1;
            y.st.mode = MODE_SKIP;
        end
        return y;
    endfunction

    // Byte handling in read mode; quote test has priority.
    function automatic ctx_t read_byte(ctx_t x, cfg_t c, logic [7:0] b, logic fin);
        ctx_t y;
        logic done_q;
        y = x;
        done_q = 1'b0;
        if (!fin && b == c.quote_char)
        begin
            if (y.st.in_quotes)
            begin
                y.st.mode = MODE_QUOTE;
                done_q = 1'b1;
            end
            else if (!y.st.field_nonempty)
            begin
                y.st.in_quotes = 1'b1;
                done_q = 1'b1;
            end
            else if (!c.lenient)
            begin
                y.st.err = ERR_QUOTE_IN_PLAIN;
                done_q = 1'b1;
            end
        end
        if (!done_q)
        begin
            priority if (y.st.in_quotes && fin)
            begin
                if (c.lenient)
                begin
                    y = close_field(y, 1'b1);
                end
                else
                begin
                    y.st.err = ERR_UNTERMINATED;
                end
            end
            else if (!y.st.in_quotes && !fin && b == c.delimiter)
            begin
                y = close_field(y, 1'b0);
            end
            else if (!y.st.in_quotes && (fin || b == CH_CR || b == CH_LF))
            begin
                y = close_field(y, 1'b1);
            end
            else
            begin
                y = push_byte(y, b);
            end
        end
        return y;
    endfunction

    logic [7:0] b;
    logic       fin;
    ctx_t       x;

    assign b   = item.in_byte;
    assign fin = item.at_end || (item.in_byte == CH_NUL);

    always_comb
    begin
        x.st  = st;
        x.res = '0;
        if (x.st.err == ERR_NONE && x.st.mode != MODE_DONE)
        begin
            // position moves before the byte is parsed
            if (!fin)
            begin
                if (b == CH_LF)
                begin
                    if (x.st.line != '1)
                    begin
                        x.st.line = x.st.line + 32'd1;
                    end
                    x.st.col = '0;
                end
                else if (x.st.col != '1)
                begin
                    x.st.col = x.st.col + 32'd1;
                end
            end
            unique case (x.st.mode)
                MODE_SKIP:
                begin
                    if (fin)
                    begin
                        x.st.mode = MODE_DONE;
                    end
                    else if (b != CH_CR && b != CH_LF)
                    begin
                        x.st.mode = MODE_READ;
                        x.st.in_quotes = 1'b0;
                        x.st.field_nonempty = 1'b0;
                        x = read_byte(x, cfg, b, 1'b0);
                    end
                end
                MODE_QUOTE:
                begin
                    // closing quote seen; decide what follows it
                    priority if (fin || b == cfg.delimiter || b == CH_CR || b == CH_LF)
                    begin
                        x.st.in_quotes = 1'b0;
                        x.st.mode = MODE_READ;
                        x = read_byte(x, cfg, b, fin);
                    end
                    else if (b == cfg.quote_char)
                    begin
                        x = push_byte(x, b);
                        x.st.mode = MODE_READ;
                    end
                    else if (cfg.lenient)
                    begin
                        x = push_byte(x, cfg.quote_char);
                        x = push_byte(x, b);
                        x.st.mode = MODE_READ;
                    end
                    else
                    begin
                        x.st.err = ERR_UNESCAPED;
                    end
                end
                MODE_READ:
                begin
                    x = read_byte(x, cfg, b, fin);
                end
                MODE_DONE:
                begin
                    x = x;
                end
            endcase
            if (x.st.err != ERR_NONE)
            begin
                x.res = '0;
            end
        end
        if (x.st.err == ERR_NONE && x.st.mode == MODE_DONE)
        begin
            x.res.done = 1'b1;
        end
    end

    assign st_next     = x.st;
    assign result.res  = x.res;
    assign result.err  = x.st.err;
    assign result.line = x.st.line;
    assign result.col  = x.st.col;

endmodule

/* rtl/csvp_out_stage.sv */
// Result register stage of the CSV field parser.
`timescale 1ns / 1ps

module csvp_out_stage
    import csvp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    advance,
    input  logic    res_valid,
    input  result_t res_in,
    output logic    out_valid,
    output result_t res_out
);

    logic    valid_reg;
    result_t res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && res_valid)
        begin
            res_reg <= res_in;
        end
    end

    assign out_valid = valid_reg;
    assign res_out   = res_reg;

endmodule

/* rtl/csv_field_parser.sv */
// Top level of the byte-serial CSV field parser.
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Usage:
//   Input channel: in_valid / in_stall carry one byte (in_byte) or an end mark
//   (at_end, or a zero byte). Output channel: out_valid / out_stall carry one
//   result per input transfer: up to two content bytes, field/row/input end
//   flags, the sticky error code and the line/column position after the byte.
//   Config channel: cfg_valid / cfg_ready with cfg_index (0 delimiter,
//   1 quote_char, 2 lenient) and cfg_data; always ready. Write only when idle.
// Timing:
//   One input register, then the parse step into the result register. Throughput
//   is one transfer per cycle while no stall holds the pipe; the parse state
//   (mode, quote flags, error, 32-bit counters) updates with each transfer.
// Stall:
//   When the result register holds a transfer and out_stall is high, the whole
//   pipe freezes and in_stall rises in the same cycle.
// Reset:
//   Registers return to comma / double quote / strict, parser in newline-skip
//   mode, line 1, column 0, no error. Both pipe stages come up empty.

module csv_field_parser
    import csvp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  in_byte,
    input  logic        at_end,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  byte_count,
    output logic [7:0]  first_byte,
    output logic [7:0]  second_byte,
    output logic        field_end,
    output logic        row_end,
    output logic        input_done,
    output logic [1:0]  error_code,
    output logic [31:0] line_number,
    output logic [31:0] column_number,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    cfg_t    cfg_reg;
    state_t  state_reg;
    state_t  state_next;
    item_t   in_item;
    item_t   item;
    logic    item_valid;
    logic    advance;
    result_t step_res;
    result_t res_out;
    logic    res_quiet;
    logic    res_empty;

    // pipe moves unless a held result is stalled
    assign advance   = !out_valid || !out_stall;
    assign in_stall  = !advance;
    assign cfg_ready = 1'b1;

    assign in_item.in_byte = in_byte;
    assign in_item.at_end  = at_end;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.delimiter  <= DELIM_RESET;
            cfg_reg.quote_char <= QUOTE_RESET;
            cfg_reg.lenient    <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_DELIMITER: cfg_reg.delimiter  <= cfg_data;
                REG_QUOTE:     cfg_reg.quote_char <= cfg_data;
                REG_LENIENT:   cfg_reg.lenient    <= cfg_data[0];
                default:       cfg_reg            <= cfg_reg;
            endcase
        end
    end

    // parser state advances once per item leaving the input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.mode           <= MODE_SKIP;
            state_reg.in_quotes      <= 1'b0;
            state_reg.field_nonempty <= 1'b0;
            state_reg.err            <= ERR_NONE;
            state_reg.line           <= LINE_RESET;
            state_reg.col            <= '0;
        end
        else if (advance && item_valid)
        begin
            state_reg <= state_next;
        end
    end

    csvp_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .in_valid   (in_valid),
        .in_item    (in_item),
        .item_valid (item_valid),
        .item       (item)
    );

    csvp_step u_step (
        .cfg     (cfg_reg),
        .st      (state_reg),
        .item    (item),
        .st_next (state_next),
        .result  (step_res)
    );

    csvp_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .res_valid (item_valid),
        .res_in    (step_res),
        .out_valid (out_valid),
        .res_out   (res_out)
    );

    assign byte_count    = res_out.res.count;
    assign first_byte    = res_out.res.first;
    assign second_byte   = res_out.res.second;
    assign field_end     = res_out.res.fend;
    assign row_end       = res_out.res.rend;
    assign input_done    = res_out.res.done;
    assign error_code    = res_out.err;
    assign line_number   = res_out.line;
    assign column_number = res_out.col;

    assign res_quiet = input_done || (error_code != ERR_NONE);
    assign res_empty = (byte_count == 2'd0) && !field_end && !row_end;

    // an error, once latched, never changes
    `ASSERT_NEXT(a_err_sticky, clk, rst_n, state_reg.err != ERR_NONE, $stable(state_reg.err))
    // a row end always closes a field
    `ASSERT_IMPLY(a_row_has_field, clk, rst_n, out_valid && row_end, field_end)
    // errored or finished results carry no content
    `ASSERT_IMPLY(a_quiet_result, clk, rst_n, out_valid && res_quiet, res_empty)
    // never more than two content bytes
    `ASSERT_IMPLY(a_count_range, clk, rst_n, out_valid, byte_count != 2'd3)

endmodule
